// ===== hw/rtl/spimb_pkg.sv =====
// ----------------------------------------------------------------------------
// spimb_pkg
// Shared types and constants of the SPI master bit engine: action and
// register codes, phase encoding, result record and reset values.
// ----------------------------------------------------------------------------
package spimb_pkg;

	localparam int CFG_W    = 16;
	localparam int WAIT_W   = 18;
	localparam int BYTE_W   = 8;
	localparam int BITCNT_W = 4;
	localparam int ACT_W    = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

	localparam logic [CFG_W-1:0] HALF_PERIOD_RST  = 16'd1000;
	localparam logic [CFG_W-1:0] SELECT_WAIT_RST  = 16'd2000;
	localparam logic [CFG_W-1:0] RELEASE_WAIT_RST = 16'd5000;

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK     = 3'd0,
		ACT_SELECT   = 3'd1,
		ACT_DESELECT = 3'd2,
		ACT_SEND     = 3'd3,
		ACT_RECV     = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_PERIOD  = 2'd0,
		CFG_SELECT_WAIT  = 2'd1,
		CFG_RELEASE_WAIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_WAIT  = 8'b0000_0010,
		PH_TXLO  = 8'b0000_0100,
		PH_TXHI  = 8'b0000_1000,
		PH_TXEND = 8'b0001_0000,
		PH_RXHI  = 8'b0010_0000,
		PH_RXLO  = 8'b0100_0000,
		PH_RXEND = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic              sck;
		logic              mosi;
		logic              cs_n;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_done;
		logic              busy_res;
	} spimb_res_t;

endpackage

// ===== hw/rtl/spimb_core.sv =====
// ----------------------------------------------------------------------------
// spimb_core
// Engine state, configuration registers and the per-tick next-state logic.
// ----------------------------------------------------------------------------
module spimb_core import spimb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [ACT_W-1:0]     action,
	input  logic [BYTE_W-1:0]    tx_byte,
	input  logic                 miso,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output spimb_res_t           res
);

	logic [CFG_W-1:0]    half_period_q, select_wait_q, release_wait_q;
	phase_t              phase_q, phase_d;
	logic [BITCNT_W-1:0] bit_cnt_q, bit_cnt_d;
	logic [BYTE_W-1:0]   shift_q, shift_d;
	logic [WAIT_W-1:0]   wait_q, wait_d;
	logic                sck_q, sck_d;
	logic                mosi_q, mosi_d;
	logic                cs_q, cs_d;
	logic [BYTE_W-1:0]   rx_hold_q, rx_hold_d;
	logic                done;
	logic [CFG_W-1:0]    hp;
	logic [WAIT_W-1:0]   hp_w, hp3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q  <= HALF_PERIOD_RST;
			select_wait_q  <= SELECT_WAIT_RST;
			release_wait_q <= RELEASE_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_PERIOD:  half_period_q  <= cfg_data;
				CFG_SELECT_WAIT:  select_wait_q  <= cfg_data;
				CFG_RELEASE_WAIT: release_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero half period counts as one tick
	assign hp   = (half_period_q == '0) ? CFG_W'(1) : half_period_q;
	assign hp_w = WAIT_W'(hp);
	assign hp3  = (hp_w << 1) + hp_w;

	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		wait_d    = wait_q;
		sck_d     = sck_q;
		mosi_d    = mosi_q;
		cs_d      = cs_q;
		rx_hold_d = rx_hold_q;
		done      = 1'b0;

		if (phase_q != PH_IDLE) begin
			if (wait_q != '0) begin
				wait_d = wait_q - WAIT_W'(1);
			end
			if (wait_d == '0) begin
				case (phase_q)
					PH_TXLO: begin
						sck_d   = 1'b1;
						phase_d = PH_TXHI;
						wait_d  = hp_w;
					end
					PH_TXHI: begin
						bit_cnt_d = bit_cnt_q + BITCNT_W'(1);
						sck_d     = 1'b0;
						wait_d    = hp_w;
						if (bit_cnt_d < BITS_PER_BYTE) begin
							mosi_d  = shift_q[BYTE_W-1];
							shift_d = {shift_q[BYTE_W-2:0], 1'b0};
							phase_d = PH_TXLO;
						end else begin
							phase_d = PH_TXEND;
						end
					end
					PH_TXEND: begin
						mosi_d  = 1'b0;
						phase_d = PH_WAIT;
						wait_d  = hp3;
					end
					PH_RXHI: begin
						sck_d   = 1'b0;
						phase_d = PH_RXLO;
						wait_d  = hp_w;
					end
					PH_RXLO: begin
						if (bit_cnt_q < BITS_PER_BYTE) begin
							sck_d     = 1'b1;
							shift_d   = {shift_q[BYTE_W-2:0], miso};
							bit_cnt_d = bit_cnt_q + BITCNT_W'(1);
							phase_d   = PH_RXHI;
							wait_d    = hp_w;
						end else begin
							phase_d = PH_RXEND;
							wait_d  = hp3;
						end
					end
					PH_RXEND: begin
						rx_hold_d = shift_q;
						done      = 1'b1;
						phase_d   = PH_IDLE;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end

		// commands land on the tick the engine is (or becomes) idle
		if (phase_d == PH_IDLE) begin
			case (action)
				ACT_SELECT: begin
					cs_d    = 1'b0;
					phase_d = (select_wait_q == '0) ? PH_IDLE : PH_WAIT;
					wait_d  = WAIT_W'(select_wait_q);
				end
				ACT_DESELECT: begin
					cs_d    = 1'b1;
					phase_d = (release_wait_q == '0) ? PH_IDLE : PH_WAIT;
					wait_d  = WAIT_W'(release_wait_q);
				end
				ACT_SEND: begin
					bit_cnt_d = '0;
					sck_d     = 1'b0;
					mosi_d    = tx_byte[BYTE_W-1];
					shift_d   = {tx_byte[BYTE_W-2:0], 1'b0};
					phase_d   = PH_TXLO;
					wait_d    = hp_w;
				end
				ACT_RECV: begin
					bit_cnt_d = BITCNT_W'(1);
					sck_d     = 1'b1;
					shift_d   = {{(BYTE_W-1){1'b0}}, miso};
					phase_d   = PH_RXHI;
					wait_d    = hp_w;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			wait_q    <= '0;
			sck_q     <= 1'b0;
			mosi_q    <= 1'b0;
			cs_q      <= 1'b1;
			rx_hold_q <= '0;
		end else if (acc) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			wait_q    <= wait_d;
			sck_q     <= sck_d;
			mosi_q    <= mosi_d;
			cs_q      <= cs_d;
			rx_hold_q <= rx_hold_d;
		end
	end

	assign res.sck      = sck_d;
	assign res.mosi     = mosi_d;
	assign res.cs_n     = cs_d;
	assign res.rx_byte  = rx_hold_d;
	assign res.rx_done  = done;
	assign res.busy_res = (phase_d != PH_IDLE);

endmodule

// ===== hw/rtl/spimb_skid.sv =====
// ----------------------------------------------------------------------------
// spimb_skid
// Two-entry result buffer: output register plus one skid entry.
// ----------------------------------------------------------------------------
module spimb_skid import spimb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  spimb_res_t push_data,
	output logic       full,
	output logic       out_valid,
	input  logic       out_stall,
	output spimb_res_t out_data
);

	logic       out_v_q, skid_v_q;
	spimb_res_t out_q, skid_q;
	logic       take;

	assign take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_v_q && !take) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/spi_master_bit_engine_top.sv =====
// ----------------------------------------------------------------------------
// spi_master_bit_engine_top
// Mode 0 half-duplex SPI master driven by timebase ticks, one result per tick.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  in       | in_valid / in_stall          | action, tx_byte, miso
//  out      | out_valid / out_stall        | sck, mosi, cs_n, rx_byte,
//           |                              | rx_done, busy_res
//  cfg      | cfg_we (index, data)         | cfg_index, cfg_data
//
//  One tick is accepted per clock while in_stall is low; its result is computed
//  by the single engine update between the state registers and the output
//  register, and is registered there, or in the skid entry if the output stalls.
//  Reset clears the engine to idle with cs_n high and loads half_period 1000,
//  select_wait 2000, release_wait 5000.
//  A two-entry output buffer absorbs downstream stalls: in_stall rises only
//  once both entries hold undelivered results.
// ----------------------------------------------------------------------------
module spi_master_bit_engine_top import spimb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// tick input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACT_W-1:0]     action,
	input  logic [BYTE_W-1:0]    tx_byte,
	input  logic                 miso,
	// pin levels out
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 sck,
	output logic                 mosi,
	output logic                 cs_n,
	output logic [BYTE_W-1:0]    rx_byte,
	output logic                 rx_done,
	output logic                 busy_res,
	// register writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic       acc;
	logic       full;
	spimb_res_t res;
	spimb_res_t res_out;

	// advance the engine on every transfer in; stall only when the buffer is full
	assign acc      = in_valid && !full;
	assign in_stall = full;

	spimb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.action    (action),
		.tx_byte   (tx_byte),
		.miso      (miso),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);

	// hold results until the consumer takes them
	spimb_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign sck      = res_out.sck;
	assign mosi     = res_out.mosi;
	assign cs_n     = res_out.cs_n;
	assign rx_byte  = res_out.rx_byte;
	assign rx_done  = res_out.rx_done;
	assign busy_res = res_out.busy_res;

endmodule

// ===== hw/rtl/spimb_checker.sv =====
// ----------------------------------------------------------------------------
// spimb_checker
// Port-level checks of the SPI master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module spimb_checker import spimb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              sck,
	input logic              mosi,
	input logic              cs_n,
	input logic [BYTE_W-1:0] rx_byte,
	input logic              rx_done,
	input logic              busy_res
);

	// leaving reset: buffer empty, input open
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> (!out_valid && !in_stall))
		else $error("buffer not empty after reset");

	// the buffer can only be full while a result is on offer
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	// a transfer into an empty buffer shows up next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> out_valid)
		else $error("accepted tick produced no result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(sck) && $stable(mosi)
			&& $stable(cs_n) && $stable(rx_byte) && $stable(rx_done)
			&& $stable(busy_res)))
		else $error("stalled result changed");

endmodule

bind spi_master_bit_engine_top spimb_checker u_spimb_checker (.*);

// ===== test/spimb_pin_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spimb_pin_checker
// Watches the tick, pin and register ports of the SPI master bit engine,
// predicts the pin levels of every accepted tick and compares each delivered
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module spimb_pin_checker import spimb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [ACT_W-1:0]     action,
	input  logic [BYTE_W-1:0]    tx_byte,
	input  logic                 miso,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 sck,
	input  logic                 mosi,
	input  logic                 cs_n,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 rx_done,
	input  logic                 busy_res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending,
	output logic                 engine_busy
);

	localparam int MAX_PRINTS = 40;
	localparam logic [WAIT_W-1:0] TAIL_HALVES = WAIT_W'(3);

	typedef struct packed {
		phase_t              phase;
		logic [BITCNT_W-1:0] bits;
		logic [BYTE_W-1:0]   shreg;
		logic [WAIT_W-1:0]   wait_left;
		logic                sck;
		logic                mosi;
		logic                cs_n;
		logic [BYTE_W-1:0]   rx_last;
	} engine_state_t;

	engine_state_t    eng;
	logic [CFG_W-1:0] half_cfg;
	logic [CFG_W-1:0] sel_cfg;
	logic [CFG_W-1:0] rel_cfg;
	spimb_res_t       pin_levels_q[$];
	int               mism = 0;
	int               results = 0;

	task automatic note_fail(string msg);
		mism++;
		if (mism <= MAX_PRINTS)
			$display("%0t pin check: %s", $time, msg);
	endtask

	task automatic cmp_pin(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
		if (got !== want)
			note_fail($sformatf("result %0d: %s is %h, expected %h", results, name, got, want));
	endtask

	function automatic logic [WAIT_W-1:0] half_len();
		return (half_cfg == '0) ? WAIT_W'(1) : WAIT_W'(half_cfg);
	endfunction

	function automatic void reset_engine();
		eng = '0;
		eng.phase = PH_IDLE;
		eng.cs_n = 1'b1;
		half_cfg = HALF_PERIOD_RST;
		sel_cfg = SELECT_WAIT_RST;
		rel_cfg = RELEASE_WAIT_RST;
	endfunction

	// drive SCK low and put the next bit on MOSI
	function automatic void shift_out();
		eng.sck = 1'b0;
		eng.mosi = eng.shreg[BYTE_W-1];
		eng.shreg = eng.shreg << 1;
		eng.phase = PH_TXLO;
		eng.wait_left = half_len();
	endfunction

	// raise SCK and take MISO on the same tick
	function automatic void shift_in(logic m);
		eng.sck = 1'b1;
		eng.shreg = {eng.shreg[BYTE_W-2:0], m};
		eng.bits = eng.bits + BITCNT_W'(1);
		eng.phase = PH_RXHI;
		eng.wait_left = half_len();
	endfunction

	function automatic void hold_cs(logic [CFG_W-1:0] ticks);
		if (ticks == '0) begin
			eng.phase = PH_IDLE;
			eng.wait_left = '0;
		end else begin
			eng.phase = PH_WAIT;
			eng.wait_left = WAIT_W'(ticks);
		end
	endfunction

	function automatic spimb_res_t run_tick(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] txb,
			logic m);
		spimb_res_t r;
		logic       done;
		done = 1'b0;
		if (eng.phase != PH_IDLE) begin
			if (eng.wait_left != '0)
				eng.wait_left = eng.wait_left - WAIT_W'(1);
			if (eng.wait_left == '0) begin
				case (eng.phase)
					PH_TXLO: begin
						eng.sck = 1'b1;
						eng.phase = PH_TXHI;
						eng.wait_left = half_len();
					end
					PH_TXHI: begin
						eng.bits = eng.bits + BITCNT_W'(1);
						if (eng.bits < BITS_PER_BYTE) begin
							shift_out();
						end else begin
							eng.sck = 1'b0;
							eng.phase = PH_TXEND;
							eng.wait_left = half_len();
						end
					end
					PH_TXEND: begin
						eng.mosi = 1'b0;
						eng.phase = PH_WAIT;
						eng.wait_left = TAIL_HALVES * half_len();
					end
					PH_RXHI: begin
						eng.sck = 1'b0;
						eng.phase = PH_RXLO;
						eng.wait_left = half_len();
					end
					PH_RXLO: begin
						if (eng.bits < BITS_PER_BYTE) begin
							shift_in(m);
						end else begin
							eng.phase = PH_RXEND;
							eng.wait_left = TAIL_HALVES * half_len();
						end
					end
					PH_RXEND: begin
						eng.rx_last = eng.shreg;
						done = 1'b1;
						eng.phase = PH_IDLE;
					end
					default: eng.phase = PH_IDLE;
				endcase
			end
		end
		// a command lands only on an idle engine, including the tick a wait runs out
		if (eng.phase == PH_IDLE) begin
			case (act)
				ACT_SELECT: begin
					eng.cs_n = 1'b0;
					hold_cs(sel_cfg);
				end
				ACT_DESELECT: begin
					eng.cs_n = 1'b1;
					hold_cs(rel_cfg);
				end
				ACT_SEND: begin
					eng.shreg = txb;
					eng.bits = '0;
					shift_out();
				end
				ACT_RECV: begin
					eng.shreg = '0;
					eng.bits = '0;
					shift_in(m);
				end
				default: ;
			endcase
		end
		r.sck = eng.sck;
		r.mosi = eng.mosi;
		r.cs_n = eng.cs_n;
		r.rx_byte = eng.rx_last;
		r.rx_done = done;
		r.busy_res = (eng.phase != PH_IDLE);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		spimb_res_t got;
		spimb_res_t want;
		if (!arst_n) begin
			reset_engine();
			pin_levels_q.delete();
			pending <= 0;
			engine_busy <= 1'b0;
			errors <= mism;
		end else begin
			if (out_valid && !out_stall) begin
				got = {sck, mosi, cs_n, rx_byte, rx_done, busy_res};
				if (pin_levels_q.size() == 0) begin
					note_fail($sformatf("result %0d arrived with no tick waiting", results));
				end else begin
					want = pin_levels_q.pop_front();
					cmp_pin("sck", BYTE_W'(got.sck), BYTE_W'(want.sck));
					cmp_pin("mosi", BYTE_W'(got.mosi), BYTE_W'(want.mosi));
					cmp_pin("cs_n", BYTE_W'(got.cs_n), BYTE_W'(want.cs_n));
					cmp_pin("rx_byte", got.rx_byte, want.rx_byte);
					cmp_pin("rx_done", BYTE_W'(got.rx_done), BYTE_W'(want.rx_done));
					cmp_pin("busy_res", BYTE_W'(got.busy_res), BYTE_W'(want.busy_res));
				end
				results++;
			end
			if (in_valid && !in_stall)
				pin_levels_q.push_back(run_tick(action, tx_byte, miso));
			// a register written at this edge applies from the next tick on
			if (cfg_we) begin
				case (cfg_index)
					CFG_HALF_PERIOD:  half_cfg = cfg_data;
					CFG_SELECT_WAIT:  sel_cfg = cfg_data;
					CFG_RELEASE_WAIT: rel_cfg = cfg_data;
					default: ;
				endcase
			end
			pending <= pin_levels_q.size();
			engine_busy <= (eng.phase != PH_IDLE);
			errors <= mism;
		end
	end

endmodule

// ===== test/spi_master_bit_engine_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_master_bit_engine_top_tb
// Feeds timebase ticks and register writes to the SPI master bit engine under
// random gaps and output stalls; spimb_pin_checker predicts and compares.
// ----------------------------------------------------------------------------
module spi_master_bit_engine_top_tb;
	import spimb_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 11;
	localparam int NUM_PHASES      = 8;
	localparam int TICKS_PER_PHASE = 206;
	localparam int HOLD_PHASE      = 2;
	localparam int HOLD_CYCLES     = 150;
	localparam int SETTLE_BURST    = 8;
	localparam int TAIL_CYCLES     = 16;
	localparam int CYCLE_LIMIT     = 1_000_000;

	// action codes the engine treats as plain ticks
	localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
	localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;
	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [CFG_W-1:0]     CFG_MAX    = 16'hFFFF;

	// One random phase: register values, commands kept out of it and whether
	// both sides run without idling. A register set to its maximum is only
	// written, never loaded: the commands that would load it are left out.
	typedef struct packed {
		logic [CFG_W-1:0] half;
		logic [CFG_W-1:0] sel;
		logic [CFG_W-1:0] rel;
		logic             skip_select;
		logic             skip_deselect;
		logic             skip_xfer;
		logic             calm;
	} phase_cfg_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ACT_W-1:0]     action = ACT_TICK;
	logic [BYTE_W-1:0]    tx_byte = '0;
	logic                 miso = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 sck;
	logic                 mosi;
	logic                 cs_n;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 rx_done;
	logic                 busy_res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HALF_PERIOD;
	logic [CFG_W-1:0]     cfg_data = '0;

	int   errors;
	int   pending;
	logic engine_busy;
	int   cycle_cnt = 0;

	// handshake between stimulus and the receiver process
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit holding = 1'b0;

	spi_master_bit_engine_top dut (.*);

	spimb_pin_checker u_pin_checker (.*);

	always #CLK_HALF clk = ~clk;

	// Bound the run: a hang or a lost result ends here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("spi_master_bit_engine_top_tb: done, errors");
			$finish;
		end
	end

	// Gap length for either side: mostly none or short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic phase_cfg_t plan_of(int idx);
		phase_cfg_t p;
		p = '0;
		case (idx)
			0: begin
				p.half = 16'd1; p.sel = 16'd1; p.rel = 16'd1;
			end
			1: begin
				p.half = 16'd2; p.sel = 16'd0; p.rel = 16'd3; p.calm = 1'b1;
			end
			2: begin
				p.half = 16'd3; p.sel = 16'd5; p.rel = 16'd0;
			end
			3: begin
				p.half = 16'd1; p.sel = CFG_MAX; p.rel = 16'd2; p.skip_select = 1'b1;
			end
			4: begin
				p.half = 16'd2; p.sel = 16'd2; p.rel = CFG_MAX; p.skip_deselect = 1'b1;
			end
			5: begin
				p.half = CFG_MAX; p.sel = 16'd1; p.rel = 16'd1; p.skip_xfer = 1'b1;
			end
			6: begin
				p.half = 16'd4; p.sel = 16'd7; p.rel = 16'd9; p.calm = 1'b1;
			end
			default: begin
				p.half = 16'd1; p.sel = 16'd0; p.rel = 16'd0;
			end
		endcase
		return p;
	endfunction

	// Commands are weighted so the engine spends most of its time at work;
	// commands that land while it is busy fall back to plain ticks.
	function automatic logic [ACT_W-1:0] pick_action(phase_cfg_t p);
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return ACT_TICK;
		if (r < 55)
			return p.skip_select ? ACT_TICK : ACT_SELECT;
		if (r < 65)
			return p.skip_deselect ? ACT_TICK : ACT_DESELECT;
		if (r < 78)
			return p.skip_xfer ? ACT_TICK : ACT_SEND;
		if (r < 91)
			return p.skip_xfer ? ACT_TICK : ACT_RECV;
		return ACT_RSVD5 + ACT_W'($urandom_range(2));
	endfunction

	// Offer one tick and hold it until the transfer; returns at the accepting
	// edge so the next tick can follow with no gap.
	task automatic put_tick(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data, logic level);
		int gap;
		gap = (calm || holding) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		tx_byte <= data;
		miso <= level;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic put_random_tick(logic [ACT_W-1:0] act);
		put_tick(act, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// Drop valid and wait until every predicted result has been delivered.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Tick the engine until it is idle, so no wait is running when a half
	// period is changed.
	task automatic settle_engine();
		wait_drained();
		while (engine_busy) begin
			repeat (SETTLE_BURST) put_random_tick(ACT_TICK);
			wait_drained();
		end
	endtask

	// Leaves the write enable high; set_config drops it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(logic [CFG_W-1:0] half, logic [CFG_W-1:0] sel,
			logic [CFG_W-1:0] rel);
		write_reg(CFG_HALF_PERIOD, half);
		write_reg(CFG_SELECT_WAIT, sel);
		write_reg(CFG_RELEASE_WAIT, rel);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stall runs, plus one long hold-off on request. While
	// holding, the sender keeps offering ticks so the output buffer fills and
	// the engine has to stall its input.
	initial begin : out_side
		int n;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				holding = 1'b1;
				n = HOLD_CYCLES;
			end else begin
				n = calm ? 0 : idle_len();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			holding = 1'b0;
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin : stimulus
		phase_cfg_t p;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Zero half period counts as one tick; a write to the
		// unused index must change nothing.
		write_reg(CFG_UNUSED, 16'h5A5A);
		set_config(16'd0, 16'd2, 16'd0);
		// rx_byte reads zero before any receive has finished
		put_tick(ACT_TICK, 8'h00, 1'b0);
		put_tick(ACT_RSVD5, 8'hFF, 1'b1);
		// select holds the engine for two ticks
		put_tick(ACT_SELECT, 8'h00, 1'b0);
		// send while busy: ignored
		put_tick(ACT_SEND, 8'h3C, 1'b1);
		// deselect lands on the tick the select wait runs out; zero release wait
		put_tick(ACT_DESELECT, 8'hFF, 1'b0);
		put_tick(ACT_RSVD7, 8'h00, 1'b1);
		// send with cs_n high goes ahead anyway
		put_tick(ACT_SEND, 8'hFF, 1'b0);
		put_tick(ACT_RECV, 8'h00, 1'b1);
		put_tick(ACT_RSVD6, 8'hA5, 1'b0);
		put_tick(ACT_TICK, 8'h5A, 1'b1);
		// change the half period mid-send; it applies from the next loaded wait
		wait_drained();
		set_config(16'd2, 16'd2, 16'd0);
		settle_engine();

		// Random phases, each with its own register set.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			p = plan_of(ph);
			if (p.skip_xfer)
				settle_engine();
			else
				wait_drained();
			set_config(p.half, p.sel, p.rel);
			calm = p.calm;
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				if (ph == HOLD_PHASE && k == TICKS_PER_PHASE / 2)
					hold_req = 1'b1;
				put_random_tick(pick_action(p));
			end
		end
		calm = 1'b0;

		// Drain, then give a stray extra result time to show up.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("spi_master_bit_engine_top_tb: done, clean");
		else
			$display("spi_master_bit_engine_top_tb: done, errors");
		$finish;
	end

endmodule
